### rtl/ffba_pkg.sv
// Shared types, codes and defaults for the first-fit block allocator.
package ffba_pkg;

    localparam int FIELD_W           = 24;
    localparam int OP_W              = 2;
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int ADDR_BITS_DEF     = 24;

    localparam logic [FIELD_W-1:0] POOL_RESET = 24'd65536;

    // Operation codes of an input item
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Result status codes
    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_NOFIT = 1'b1;

    // What the cells do with a passing token
    typedef enum logic [1:0] {
        MODE_FIT,
        MODE_SLOT,
        MODE_FREE
    } cell_mode_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        cell_mode_t mode;
        logic       clear;
        logic       unmark;
    } ffba_ctl_t;

    // Token flags handed from cell to cell
    typedef struct packed {
        logic act;
        logic pend;
    } ffba_tok_t;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [FIELD_W-1:0] request_size;
        logic [FIELD_W-1:0] free_start;
    } ffba_in_t;

    typedef struct packed {
        logic               status;
        logic [FIELD_W-1:0] alloc_start;
    } ffba_out_t;

endpackage

### rtl/ffba_cell.sv
// One table entry of the allocator chain, with its token stage.
module ffba_cell #(
    parameter int ADDR_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ffba_pkg::ffba_ctl_t  ctl_i,
    input  logic [ADDR_BITS-1:0] key_i,
    input  logic [ADDR_BITS-1:0] init_size_i,
    input  logic [ADDR_BITS-1:0] clr_size_i,
    input  ffba_pkg::ffba_tok_t  tok_i,
    input  logic [ADDR_BITS-1:0] tok_begin_i,
    input  logic [ADDR_BITS-1:0] tok_size_i,
    output ffba_pkg::ffba_tok_t  tok_o,
    output logic [ADDR_BITS-1:0] tok_begin_o,
    output logic [ADDR_BITS-1:0] tok_size_o
);
    import ffba_pkg::*;

    logic [ADDR_BITS-1:0] entry_begin_reg, entry_begin_next;
    logic [ADDR_BITS-1:0] entry_size_reg,  entry_size_next;
    logic                 entry_used_reg,  entry_used_next;
    logic                 mark_reg,        mark_next;
    ffba_tok_t            tok_reg,         tok_next;
    logic [ADDR_BITS-1:0] tok_begin_reg,   tok_begin_next;
    logic [ADDR_BITS-1:0] tok_size_reg,    tok_size_next;

    logic live;
    logic fit_hit;
    logic slot_hit;
    logic free_hit;

    // Decide whether this entry takes the token
    assign live     = tok_i.act && tok_i.pend;
    assign fit_hit  = live && (ctl_i.mode == MODE_FIT) && !entry_used_reg
                      && (entry_size_reg >= key_i);
    assign slot_hit = live && (ctl_i.mode == MODE_SLOT) && !mark_reg
                      && (entry_size_reg == '0);
    assign free_hit = live && (ctl_i.mode == MODE_FREE) && (entry_begin_reg == key_i);

    // Update the entry and build the token for the next cell
    always_comb begin
        entry_begin_next = entry_begin_reg;
        entry_size_next  = entry_size_reg;
        entry_used_next  = entry_used_reg;
        mark_next        = mark_reg;

        tok_next.act     = tok_i.act;
        tok_next.pend    = tok_i.pend && !(fit_hit || slot_hit || free_hit);
        tok_begin_next   = tok_begin_i;
        tok_size_next    = tok_size_i;

        if (fit_hit) begin
            // grant this entry; hand the remainder down the chain
            entry_used_next = 1'b1;
            entry_size_next = key_i;
            mark_next       = 1'b1;
            tok_begin_next  = entry_begin_reg + key_i;
            tok_size_next   = entry_size_reg - key_i;
        end
        if (slot_hit) begin
            entry_begin_next = tok_begin_i;
            entry_size_next  = tok_size_i;
            entry_used_next  = 1'b0;
        end
        if (free_hit) begin
            entry_used_next = 1'b0;
        end
        if (ctl_i.unmark) begin
            mark_next = 1'b0;
        end
        if (ctl_i.clear) begin
            entry_begin_next = '0;
            entry_size_next  = clr_size_i;
            entry_used_next  = 1'b0;
            mark_next        = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_begin_reg <= '0;
            entry_size_reg  <= init_size_i;
            entry_used_reg  <= 1'b0;
            mark_reg        <= 1'b0;
            tok_reg         <= '0;
        end else begin
            entry_begin_reg <= entry_begin_next;
            entry_size_reg  <= entry_size_next;
            entry_used_reg  <= entry_used_next;
            mark_reg        <= mark_next;
            tok_reg         <= tok_next;
        end
        tok_begin_reg <= tok_begin_next;
        tok_size_reg  <= tok_size_next;
    end

    assign tok_o       = tok_reg;
    assign tok_begin_o = tok_begin_reg;
    assign tok_size_o  = tok_size_reg;

endmodule

### rtl/first_fit_block_allocator.sv
// Top level: first-fit block allocator built as a chain of table cells.
//
//   channel | ports                          | direction | payload
//   --------+--------------------------------+-----------+--------------------------
//   request | s_valid s_ready s_data         | in        | operation, size, address
//   result  | m_valid m_ready m_data         | out       | status, alloc_start
//   config  | cfg_wr_en cfg_wr_data          | in        | pool_size
//
// A token walks the cell chain one entry per cycle. An allocate runs two passes (find the
// fit, then place the remainder); an allocate with no fit and a free run one pass; a clear
// reloads the table with no pass, and an unused code goes straight to the result.
// The next item can be taken once its result is loaded.
// Reset is synchronous and loads the table with one free pool of 65536 bytes.
// A result waits in the output register while the next item is taken; a second result
// held by m_ready low stalls the input.
module first_fit_block_allocator #(
    parameter int TABLE_ENTRIES = ffba_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_BITS     = ffba_pkg::ADDR_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ffba_pkg::ffba_in_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ffba_pkg::ffba_out_t           m_data,
    input  logic                          cfg_wr_en,
    input  logic [ffba_pkg::FIELD_W-1:0]  cfg_wr_data
);
    import ffba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_FIT,
        S_SLOT,
        S_FREE,
        S_DONE
    } state_t;

    state_t               state_reg,     state_next;
    logic                 launch_reg,    launch_next;
    logic [ADDR_BITS-1:0] key_reg,       key_next;
    logic [ADDR_BITS-1:0] inj_begin_reg, inj_begin_next;
    logic [ADDR_BITS-1:0] inj_size_reg,  inj_size_next;
    ffba_out_t            res_reg,       res_next;
    logic                 m_valid_reg,   m_valid_next;
    ffba_out_t            m_data_reg,    m_data_next;
    logic [FIELD_W-1:0]   pool_reg;

    ffba_ctl_t            ctl;
    ffba_tok_t            tok     [TABLE_ENTRIES+1];
    logic [ADDR_BITS-1:0] tok_beg [TABLE_ENTRIES+1];
    logic [ADDR_BITS-1:0] tok_sz  [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] act_vec;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg <= POOL_RESET;
        end else if (cfg_wr_en) begin
            pool_reg <= cfg_wr_data;
        end
    end

    // Broadcast control and token injection at the head of the chain
    always_comb begin
        case (state_reg)
            S_FIT:   ctl.mode = MODE_FIT;
            S_SLOT:  ctl.mode = MODE_SLOT;
            default: ctl.mode = MODE_FREE;
        endcase
        ctl.clear  = (state_reg == S_CLEAR);
        ctl.unmark = (state_reg == S_SLOT) && tok[TABLE_ENTRIES].act;
    end

    assign tok[0].act  = launch_reg;
    assign tok[0].pend = launch_reg;
    assign tok_beg[0]  = inj_begin_reg;
    assign tok_sz[0]   = inj_size_reg;

    // Row of table cells
    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        logic [ADDR_BITS-1:0] init_size;
        logic [ADDR_BITS-1:0] clr_size;

        assign init_size  = (k == 0) ? ADDR_BITS'(POOL_RESET) : '0;
        assign clr_size   = (k == 0) ? ADDR_BITS'(pool_reg) : '0;
        assign act_vec[k] = tok[k+1].act;

        ffba_cell #(
            .ADDR_BITS (ADDR_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl_i       (ctl),
            .key_i       (key_reg),
            .init_size_i (init_size),
            .clr_size_i  (clr_size),
            .tok_i       (tok[k]),
            .tok_begin_i (tok_beg[k]),
            .tok_size_i  (tok_sz[k]),
            .tok_o       (tok[k+1]),
            .tok_begin_o (tok_beg[k+1]),
            .tok_size_o  (tok_sz[k+1])
        );
    end

    // Sequencer: accept, run passes, deliver the result
    always_comb begin
        state_next     = state_reg;
        launch_next    = 1'b0;
        key_next       = key_reg;
        inj_begin_next = inj_begin_reg;
        inj_size_next  = inj_size_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_next       = '0;
                    inj_begin_next = '0;
                    inj_size_next  = '0;
                    case (s_data.operation)
                        OP_ALLOC: begin
                            key_next    = ADDR_BITS'(s_data.request_size);
                            launch_next = 1'b1;
                            state_next  = S_FIT;
                        end
                        OP_FREE: begin
                            key_next    = ADDR_BITS'(s_data.free_start);
                            launch_next = 1'b1;
                            state_next  = S_FREE;
                        end
                        OP_CLEAR: begin
                            state_next = S_CLEAR;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                state_next = S_DONE;
            end
            S_FIT: begin
                if (tok[TABLE_ENTRIES].act) begin
                    if (tok[TABLE_ENTRIES].pend) begin
                        res_next.status      = STATUS_NOFIT;
                        res_next.alloc_start = '0;
                        state_next           = S_DONE;
                    end else begin
                        // grant start is the remainder start less the request
                        res_next.status      = STATUS_DONE;
                        res_next.alloc_start =
                            FIELD_W'(tok_beg[TABLE_ENTRIES] - key_reg);
                        inj_begin_next       = tok_beg[TABLE_ENTRIES];
                        inj_size_next        = tok_sz[TABLE_ENTRIES];
                        launch_next          = 1'b1;
                        state_next           = S_SLOT;
                    end
                end
            end
            S_SLOT, S_FREE: begin
                if (tok[TABLE_ENTRIES].act) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            launch_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            launch_reg  <= launch_next;
            m_valid_reg <= m_valid_next;
        end
        key_reg       <= key_next;
        inj_begin_reg <= inj_begin_next;
        inj_size_reg  <= inj_size_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // At most one token travels the chain
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(act_vec))
        else $error("more than one token in the cell chain");

    // The chain is empty whenever a new item may be taken
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (act_vec == '0 && !launch_reg))
        else $error("token left in chain while idle");

    // A failed allocate reports a zero start address
    a_nofit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status == STATUS_NOFIT) |-> (m_data_reg.alloc_start == '0))
        else $error("no-fit result carries a start address");

    // A result is loaded only from the done state
    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result loaded outside the done state");

endmodule
